### rtl/kcl_pkg.sv
// Shared constants and types for the keypad code lock.
`timescale 1ns / 1ps

package kcl_pkg;

   localparam int MAX_CODE_LEN = 8;

   localparam logic [3:0] KEY_CONFIRM = 4'd10;
   localparam logic [3:0] KEY_STAR    = 4'd14;
   localparam logic [3:0] KEY_HASH    = 4'd15;

   localparam logic [2:0] MODE_IDLE   = 3'd0;
   localparam logic [2:0] MODE_UNLOCK = 3'd1;
   localparam logic [2:0] MODE_OLD    = 3'd2;
   localparam logic [2:0] MODE_NEW1   = 3'd3;
   localparam logic [2:0] MODE_NEW2   = 3'd4;

   localparam logic [2:0] EV_NONE      = 3'd0;
   localparam logic [2:0] EV_UNLOCKED  = 3'd1;
   localparam logic [2:0] EV_WRONG     = 3'd2;
   localparam logic [2:0] EV_CHANGED   = 3'd3;
   localparam logic [2:0] EV_MISMATCH  = 3'd4;
   localparam logic [2:0] EV_WRONG_OLD = 3'd5;

   localparam logic [3:0] FAIL_MAX         = 4'd15;
   localparam logic [3:0] FAIL_LIMIT_RESET = 4'd3;

   // factory code, digits beyond the fourth are zero
   localparam logic [3:0] DEFAULT_CODE [MAX_CODE_LEN] =
      '{4'd2, 4'd0, 4'd2, 4'd1, 4'd0, 4'd0, 4'd0, 4'd0};

   // strobes from the sequencer to the code stores
   typedef struct packed {
      logic wr_first;   // write key into first new-code buffer
      logic copy_code;  // replace stored code with first new-code buffer
      logic use_first;  // compare against first new-code buffer
   } ctl_type;

endpackage

### rtl/kcl_ctrl.sv
// Entry sequencer: phase, entry length and match, failure count, alarm and result register.
`timescale 1ns / 1ps

module kcl_ctrl #(
   parameter int CODE_LEN = 4,
   localparam int CNT_W = $clog2(CODE_LEN + 2),
   localparam int IDX_W = (CODE_LEN > 1) ? $clog2(CODE_LEN) : 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  logic [3:0]       key,
   input  logic [3:0]       ref_key,
   input  logic [3:0]       fail_limit,
   output logic [IDX_W-1:0] idx,
   output kcl_pkg::ctl_type ctl,
   output logic [2:0]       mode_ff,
   output logic [2:0]       event_ff,
   output logic             alarm_ff,
   output logic             echo_ff
);
   import kcl_pkg::*;

   typedef enum logic [2:0] {
      PH_IDLE   = MODE_IDLE,
      PH_UNLOCK = MODE_UNLOCK,
      PH_OLD    = MODE_OLD,
      PH_NEW1   = MODE_NEW1,
      PH_NEW2   = MODE_NEW2
   } phase_type;

   localparam logic [CNT_W-1:0] LEN = CNT_W'(CODE_LEN);

   phase_type        phase_ff, phase_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             match_ff, match_in;
   logic [3:0]       fail_ff, fail_in, fail_inc;
   logic             alarm_in;
   logic [2:0]       ev_in;
   logic             echo_in;
   logic             short_entry;
   logic             entry_ok;
   logic [CNT_W-1:0] count_take;
   logic             match_take;

   assign short_entry = (count_ff < LEN);
   assign entry_ok    = match_ff && (count_ff == LEN);
   assign idx         = count_ff[IDX_W-1:0];
   assign fail_inc    = (fail_ff < FAIL_MAX) ? fail_ff + 4'd1 : fail_ff;

   // count saturates one past the code length so overlong entries never match
   always_comb begin
      count_take = (count_ff <= LEN) ? count_ff + CNT_W'(1) : count_ff;
      match_take = short_entry ? (match_ff && (ref_key == key)) : 1'b0;
   end

   always_comb begin
      phase_in      = phase_ff;
      count_in      = count_ff;
      match_in      = match_ff;
      fail_in       = fail_ff;
      alarm_in      = alarm_ff;
      ev_in         = EV_NONE;
      echo_in       = 1'b0;
      ctl.wr_first  = 1'b0;
      ctl.copy_code = 1'b0;
      ctl.use_first = (phase_ff == PH_NEW1) || (phase_ff == PH_NEW2);

      if (phase_ff == PH_IDLE) begin
         if (key == KEY_STAR) begin
            phase_in = PH_UNLOCK;
            count_in = '0;
            match_in = 1'b1;
         end else if (key == KEY_HASH) begin
            phase_in = PH_OLD;
            count_in = '0;
            match_in = 1'b1;
         end
      end else if (key != KEY_CONFIRM) begin
         echo_in  = 1'b1;
         count_in = count_take;
         if (phase_ff == PH_NEW1) begin
            ctl.wr_first = short_entry;
            match_in     = 1'b1;
         end else begin
            match_in = match_take;
         end
      end else begin
         count_in = '0;
         match_in = 1'b1;
         phase_in = PH_IDLE;
         case (phase_ff)
            PH_UNLOCK: begin
               if (entry_ok) begin
                  ev_in    = EV_UNLOCKED;
                  fail_in  = '0;
                  alarm_in = 1'b0;
               end else begin
                  ev_in   = EV_WRONG;
                  fail_in = fail_inc;
                  if (fail_inc >= fail_limit) alarm_in = 1'b1;
               end
            end
            PH_OLD: begin
               if (entry_ok) begin
                  fail_in  = '0;
                  phase_in = PH_NEW1;
               end else begin
                  ev_in = EV_WRONG_OLD;
               end
            end
            PH_NEW1: begin
               phase_in = PH_NEW2;
               match_in = (count_ff == LEN);
            end
            PH_NEW2: begin
               if (entry_ok) begin
                  ctl.copy_code = 1'b1;
                  ev_in         = EV_CHANGED;
               end else begin
                  ev_in = EV_MISMATCH;
               end
            end
            default: phase_in = PH_IDLE;
         endcase
      end

      if (!accept) begin
         ctl.wr_first  = 1'b0;
         ctl.copy_code = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         count_ff <= '0;
         match_ff <= 1'b1;
         fail_ff  <= '0;
         alarm_ff <= 1'b0;
      end else if (accept) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         match_ff <= match_in;
         fail_ff  <= fail_in;
         alarm_ff <= alarm_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff  <= phase_in;
         event_ff <= ev_in;
         echo_ff  <= echo_in;
      end
   end

endmodule

### rtl/keypad_code_lock.sv
// Keypad code lock top level: handshake, code stores and limit register.
// The result is registered on the edge that takes the request.
// Throughput: one request per cycle; a new request is taken while a result waits,
// as long as that result is taken too.
// Reset (synchronous, active high): idle, code 2021, no failures, alarm off,
// fail limit 3. The first new-code buffer holds no reset value.
`timescale 1ns / 1ps

module keypad_code_lock #(
   parameter int CODE_LEN = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [3:0] req_key,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_mode,
   output logic [2:0] rsp_event_res,
   output logic       rsp_alarm,
   output logic       rsp_echo,
   input  logic       csr_wr_en,
   input  logic [3:0] csr_wr_data
);
   import kcl_pkg::*;

   localparam int IDX_W = (CODE_LEN > 1) ? $clog2(CODE_LEN) : 1;

   logic [3:0]       stored_code_ff [CODE_LEN];
   logic [3:0]       first_new_ff   [CODE_LEN];
   logic [3:0]       fail_limit_ff;
   logic             rsp_valid_ff;
   logic             accept;
   logic [IDX_W-1:0] idx;
   ctl_type          ctl;
   logic [3:0]       ref_key;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign ref_key   = ctl.use_first ? first_new_ff[idx] : stored_code_ff[idx];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fail_limit_ff <= FAIL_LIMIT_RESET;
      end else if (csr_wr_en) begin
         fail_limit_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CODE_LEN; i++) stored_code_ff[i] <= DEFAULT_CODE[i];
      end else if (ctl.copy_code) begin
         for (int i = 0; i < CODE_LEN; i++) stored_code_ff[i] <= first_new_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_first) first_new_ff[idx] <= req_key;
   end

   kcl_ctrl #(
      .CODE_LEN (CODE_LEN)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .key        (req_key),
      .ref_key    (ref_key),
      .fail_limit (fail_limit_ff),
      .idx        (idx),
      .ctl        (ctl),
      .mode_ff    (rsp_mode),
      .event_ff   (rsp_event_res),
      .alarm_ff   (rsp_alarm),
      .echo_ff    (rsp_echo)
   );

endmodule

### rtl/kcl_checker.sv
// Port-level checks for the keypad code lock, bound to the top level.
`timescale 1ns / 1ps

module kcl_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_mode,
   input logic [2:0] rsp_event_res,
   input logic       rsp_alarm,
   input logic       rsp_echo
);
   import kcl_pkg::*;

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_mode)
         && $stable(rsp_event_res) && $stable(rsp_alarm) && $stable(rsp_echo))
      else $error("response changed while stalled");

   // every finished entry returns to idle
   a_event_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_res != EV_NONE) |-> rsp_mode == MODE_IDLE)
      else $error("event reported outside idle");

   // an echoed key sits inside an entry and finishes nothing
   a_echo_entry: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_echo |-> (rsp_mode != MODE_IDLE) && (rsp_event_res == EV_NONE))
      else $error("echo outside an entry");

   a_unlock_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_res == EV_UNLOCKED) |-> !rsp_alarm)
      else $error("alarm still set after unlock");

   // the request side is only held off by a waiting, untaken response
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("request stalled without cause");

endmodule

bind keypad_code_lock kcl_checker u_kcl_checker (.*);

### sim/keypad_code_lock_tb.sv
// Testbench for the keypad code lock: key sequences checked against a behavioural predictor.
`timescale 1ns / 1ps

module keypad_code_lock_tb;
   import kcl_pkg::*;

   localparam int CODE_LEN = 4;
   localparam int CYCLE_LIMIT = 250000;
   localparam int RANDOM_KEYS = 480;
   localparam int STORM_LEN = 16;
   localparam logic [3:0] KEY_B = 4'd11;
   localparam logic [3:0] KEY_D = 4'd13;

   typedef logic [3:0] key_type;
   typedef struct packed {
      logic [2:0] mode;
      logic [2:0] event_res;
      logic       alarm;
      logic       echo;
   } lock_rsp_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   key_type    req_key = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [2:0] rsp_mode;
   logic [2:0] rsp_event_res;
   logic       rsp_alarm;
   logic       rsp_echo;
   logic       csr_wr_en = 1'b0;
   logic [3:0] csr_wr_data = '0;

   // predictor state
   logic [2:0]   lock_mode;
   key_type      code_store [MAX_CODE_LEN];
   key_type      first_code [MAX_CODE_LEN];
   int           keys_in;
   logic         keys_match;
   logic [3:0]   fail_cnt;
   logic [3:0]   fail_limit;
   logic         alarm_on;
   lock_rsp_type rsp_expected [$];

   // stimulus state
   key_type gen_code [CODE_LEN];
   key_type new_code [MAX_CODE_LEN];
   int      new_len;
   key_type entry_buf [MAX_CODE_LEN];
   int      entry_len;
   int      send_idle_pct = 0;
   int      stall_pct = 0;

   int errors = 0;
   int keys_sent = 0;
   int rsps_checked = 0;
   int cycles = 0;
   int ev_seen [6];

   keypad_code_lock #(
      .CODE_LEN(CODE_LEN)
   ) u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_key      (req_key),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_mode     (rsp_mode),
      .rsp_event_res(rsp_event_res),
      .rsp_alarm    (rsp_alarm),
      .rsp_echo     (rsp_echo),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timed out after %0d cycles", cycles);
         $display("keypad_code_lock_tb NOT OK");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // ---------------- predictor ----------------

   task automatic init_lock_model();
      lock_mode = MODE_IDLE;
      for (int i = 0; i < MAX_CODE_LEN; i++) begin
         code_store[i] = DEFAULT_CODE[i];
         first_code[i] = '0;
      end
      keys_in = 0;
      keys_match = 1'b1;
      fail_cnt = '0;
      fail_limit = FAIL_LIMIT_RESET;
      alarm_on = 1'b0;
      for (int i = 0; i < CODE_LEN; i++)
         gen_code[i] = DEFAULT_CODE[i];
      foreach (ev_seen[i])
         ev_seen[i] = 0;
   endtask

   task automatic restart_entry(input logic [2:0] m, input logic match_init);
      lock_mode = m;
      keys_in = 0;
      keys_match = match_init;
   endtask

   // length saturates one past the code length; overlong entries never match
   task automatic track_key(input key_type ref_k, input key_type k);
      if (keys_in < CODE_LEN) begin
         if (ref_k != k)
            keys_match = 1'b0;
         keys_in++;
      end else begin
         keys_match = 1'b0;
         if (keys_in <= CODE_LEN)
            keys_in++;
      end
   endtask

   task automatic predict_key(input key_type k, output lock_rsp_type r);
      logic [2:0] ev;
      logic       echo;
      logic       entry_good;
      ev = EV_NONE;
      echo = 1'b0;
      entry_good = keys_match && (keys_in == CODE_LEN);
      if (lock_mode == MODE_IDLE) begin
         if (k == KEY_STAR)
            restart_entry(MODE_UNLOCK, 1'b1);
         else if (k == KEY_HASH)
            restart_entry(MODE_OLD, 1'b1);
      end else if (k != KEY_CONFIRM) begin
         echo = 1'b1;
         case (lock_mode)
            MODE_NEW1: begin
               if (keys_in < CODE_LEN)
                  first_code[keys_in] = k;
               if (keys_in <= CODE_LEN)
                  keys_in++;
               keys_match = 1'b1;
            end
            MODE_NEW2: track_key(first_code[keys_in], k);
            default:   track_key(code_store[keys_in], k);
         endcase
      end else begin
         case (lock_mode)
            MODE_UNLOCK: begin
               if (entry_good) begin
                  ev = EV_UNLOCKED;
                  fail_cnt = '0;
                  alarm_on = 1'b0;
               end else begin
                  ev = EV_WRONG;
                  if (fail_cnt != FAIL_MAX)
                     fail_cnt++;
                  if (fail_cnt >= fail_limit)
                     alarm_on = 1'b1;
               end
               restart_entry(MODE_IDLE, 1'b1);
            end
            MODE_OLD: begin
               if (entry_good) begin
                  fail_cnt = '0;
                  restart_entry(MODE_NEW1, 1'b1);
               end else begin
                  ev = EV_WRONG_OLD;
                  restart_entry(MODE_IDLE, 1'b1);
               end
            end
            MODE_NEW1: restart_entry(MODE_NEW2, keys_in == CODE_LEN);
            MODE_NEW2: begin
               if (entry_good) begin
                  for (int i = 0; i < CODE_LEN; i++)
                     code_store[i] = first_code[i];
                  ev = EV_CHANGED;
               end else begin
                  ev = EV_MISMATCH;
               end
               restart_entry(MODE_IDLE, 1'b1);
            end
            default: restart_entry(MODE_IDLE, 1'b1);
         endcase
      end
      r.mode = lock_mode;
      r.event_res = ev;
      r.alarm = alarm_on;
      r.echo = echo;
   endtask

   task automatic check_field(input string what, input int want, input int got);
      if (want != got) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      end
   endtask

   always @(posedge clock) begin : response_check
      lock_rsp_type got;
      lock_rsp_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            got.mode = rsp_mode;
            got.event_res = rsp_event_res;
            got.alarm = rsp_alarm;
            got.echo = rsp_echo;
            rsps_checked++;
            if (got.event_res <= EV_WRONG_OLD)
               ev_seen[got.event_res]++;
            if (rsp_expected.size() == 0) begin
               errors++;
               $display("%0t: response with nothing expected, actual %p", $time, got);
            end else begin
               want = rsp_expected.pop_front();
               check_field("mode", want.mode, got.mode);
               check_field("event_res", want.event_res, got.event_res);
               check_field("alarm", want.alarm, got.alarm);
               check_field("echo", want.echo, got.echo);
            end
         end
         if (req_valid && req_ready) begin
            predict_key(req_key, want);
            rsp_expected.push_back(want);
         end
      end
   end

   // ---------------- stimulus helpers ----------------

   task automatic send_key(input key_type k);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_key = k;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      keys_sent++;
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_valid = 1'b0;
      while (rsp_expected.size() != 0)
         @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   task automatic set_fail_limit(input logic [3:0] lim);
      wait_idle();
      csr_wr_en = 1'b1;
      csr_wr_data = lim;
      fail_limit = lim;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   function automatic key_type any_but_confirm();
      key_type k;
      k = key_type'($urandom_range(14));
      if (k >= KEY_CONFIRM)
         k = k + 1'b1;
      return k;
   endfunction

   task automatic load_code();
      for (int i = 0; i < CODE_LEN; i++)
         entry_buf[i] = gen_code[i];
      entry_len = CODE_LEN;
   endtask

   task automatic fill_random(input int len);
      for (int i = 0; i < len; i++)
         entry_buf[i] = any_but_confirm();
      entry_len = len;
   endtask

   task automatic tweak_entry();
      int      idx;
      key_type k;
      if (entry_len > 0) begin
         idx = $urandom_range(entry_len - 1);
         k = any_but_confirm();
         while (k == entry_buf[idx])
            k = any_but_confirm();
         entry_buf[idx] = k;
      end
   endtask

   // wrong by length, by content, or both
   task automatic make_bad_entry();
      case ($urandom_range(2))
         0: fill_random($urandom_range(6));
         1: begin
            load_code();
            tweak_entry();
         end
         default: begin
            load_code();
            if ($urandom_range(1)) begin
               entry_buf[CODE_LEN] = any_but_confirm();
               entry_len = CODE_LEN + 1;
            end else begin
               entry_len = CODE_LEN - 1;
            end
         end
      endcase
   endtask

   function automatic bit entry_matches(input bit against_new);
      if (entry_len != (against_new ? new_len : CODE_LEN))
         return 1'b0;
      for (int i = 0; i < entry_len; i++)
         if (entry_buf[i] != (against_new ? new_code[i] : gen_code[i]))
            return 1'b0;
      return 1'b1;
   endfunction

   task automatic send_entry();
      for (int i = 0; i < entry_len; i++)
         send_key(entry_buf[i]);
      send_key(KEY_CONFIRM);
   endtask

   task automatic change_code_sequence();
      bit old_ok;
      bit same;
      send_key(KEY_HASH);
      if ($urandom_range(99) < 85)
         load_code();
      else
         make_bad_entry();
      old_ok = entry_matches(1'b0);
      send_entry();
      if (old_ok) begin
         if ($urandom_range(99) < 85)
            fill_random(CODE_LEN);
         else
            fill_random($urandom_range(6));
         for (int i = 0; i < entry_len; i++)
            new_code[i] = entry_buf[i];
         new_len = entry_len;
         send_entry();
         case ($urandom_range(9))
            8: tweak_entry();
            9: fill_random($urandom_range(6));
            default: ;
         endcase
         same = entry_matches(1'b1) && (new_len == CODE_LEN);
         send_entry();
         if (same)
            for (int i = 0; i < CODE_LEN; i++)
               gen_code[i] = new_code[i];
      end
   endtask

   // after arbitrary keys, confirm until idle and take the code from the predictor
   task automatic resync();
      wait_idle();
      while (lock_mode != MODE_IDLE) begin
         send_key(KEY_CONFIRM);
         wait_idle();
      end
      for (int i = 0; i < CODE_LEN; i++)
         gen_code[i] = code_store[i];
   endtask

   // ---------------- tests ----------------

   task automatic test_idle_keys();
      send_key(KEY_B);
      send_key(KEY_CONFIRM);
   endtask

   task automatic test_code_change();
      send_key(KEY_HASH);
      load_code();
      send_entry();
      entry_buf[0] = KEY_D;
      entry_buf[1] = KEY_STAR;
      entry_buf[2] = KEY_HASH;
      entry_buf[3] = 4'd0;
      entry_len = CODE_LEN;
      send_entry();
      send_entry();
      for (int i = 0; i < CODE_LEN; i++)
         gen_code[i] = entry_buf[i];
   endtask

   task automatic test_unlock();
      send_key(KEY_STAR);
      load_code();
      send_entry();
   endtask

   task automatic test_rejected_entries();
      send_key(KEY_STAR);
      send_key(KEY_CONFIRM);
      send_key(KEY_HASH);
      fill_random(1);
      send_entry();
   endtask

   task automatic test_random_sequences(input int idle_pct, input int stall_in, input int n);
      int stop_at;
      int pick;
      send_idle_pct = idle_pct;
      stall_pct = stall_in;
      stop_at = keys_sent + n;
      while (keys_sent < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 30) begin
            send_key(KEY_STAR);
            load_code();
            send_entry();
         end else if (pick < 48) begin
            send_key(KEY_STAR);
            make_bad_entry();
            send_entry();
         end else if (pick < 75) begin
            change_code_sequence();
         end else if (pick < 80) begin
            // enough failures in a row to saturate the counter
            repeat (STORM_LEN) begin
               send_key(KEY_STAR);
               send_key(KEY_CONFIRM);
            end
         end else if (pick < 92) begin
            repeat ($urandom_range(1, 4))
               send_key(key_type'($urandom_range(KEY_D)));
         end else begin
            send_key($urandom_range(1) ? KEY_STAR : KEY_HASH);
            repeat ($urandom_range(1, 8))
               send_key(key_type'($urandom_range(15)));
            resync();
         end
      end
   endtask

   initial begin
      init_lock_model();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_idle_keys();
      test_code_change();
      test_unlock();
      test_rejected_entries();

      set_fail_limit(4'd1);
      test_random_sequences(0, 0, RANDOM_KEYS);
      set_fail_limit(4'd15);
      test_random_sequences(77, 0, RANDOM_KEYS);
      set_fail_limit(4'd0);
      test_random_sequences(0, 77, RANDOM_KEYS);
      set_fail_limit(4'($urandom_range(2, 14)));
      test_random_sequences(34, 34, RANDOM_KEYS);

      wait_idle();
      repeat (5) @(negedge clock);

      $display("%0d keys sent under four idle/stall mixes, fail limits 3, 1, 15, 0 and %0d",
               keys_sent, fail_limit);
      $display("%0d responses: %0d unlocked, %0d wrong, %0d changed, %0d mismatched, %0d wrong old",
               rsps_checked, ev_seen[EV_UNLOCKED], ev_seen[EV_WRONG], ev_seen[EV_CHANGED],
               ev_seen[EV_MISMATCH], ev_seen[EV_WRONG_OLD]);
      if (errors == 0 && rsp_expected.size() == 0) begin
         $display("keypad_code_lock_tb OK");
      end else begin
         $display("%0d errors, %0d responses outstanding", errors, rsp_expected.size());
         $display("keypad_code_lock_tb NOT OK");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/kcl_pkg.sv
rtl/kcl_ctrl.sv
rtl/keypad_code_lock.sv
rtl/kcl_checker.sv
sim/keypad_code_lock_tb.sv
